// ===== hdl/dmra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the double-ended mark/release allocator.
package dmra_pkg;

  typedef enum logic [3:0] {
    OP_INIT       = 4'd0,
    OP_TOP_LOCK   = 4'd1,
    OP_TOP_UNLOCK = 4'd2,
    OP_TOP_MARK   = 4'd3,
    OP_TOP_ALLOC  = 4'd4,
    OP_TOP_FREE   = 4'd5,
    OP_BOT_LOCK   = 4'd6,
    OP_BOT_UNLOCK = 4'd7,
    OP_BOT_ALLOC  = 4'd8,
    OP_BOT_MARK   = 4'd9,
    OP_BOT_FREE   = 4'd10
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OOM          = 3'd1,
    ST_TOP_LOCKED   = 3'd2,
    ST_TOP_UNLOCKED = 3'd3,
    ST_BOT_LOCKED   = 3'd4,
    ST_BOT_UNLOCKED = 3'd5,
    ST_NO_MARK      = 3'd6,
    ST_MARKS_FULL   = 3'd7
  } status_t;

  typedef struct packed {
    logic [15:0] address;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_cmd_t;

  localparam logic [15:0] REGION_SIZE_RESET = 16'd32000;
  localparam logic        REG_REGION_SIZE   = 1'b0;

endpackage

// ===== hdl/dmra_mark_stack.sv =====
`timescale 1ns / 1ps
// Mark stack: memory of saved end pointers with a registered top-of-stack copy.
module dmra_mark_stack #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dmra_pkg::stack_cmd_t     cmd,
  input  logic [WIDTH-1:0]         push_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [WIDTH-1:0]         tos
);
  import dmra_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] top_slot;

  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  // slot that holds the top entry once this cycle's command is done
  assign top_slot = count_next - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[count[IDX_W-1:0]] <= push_data;
    end
  end

  // keep tos equal to the top entry; a push bypasses the memory
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      tos <= push_data;
    end else begin
      tos <= mem[top_slot[IDX_W-1:0]];
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push && !cmd.clear |-> count != CNT_W'(DEPTH))
    else $error("mark stack pushed while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && !cmd.clear |-> count != '0)
    else $error("mark stack popped while empty");
  a_push_pop_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("mark stack push and pop together");

endmodule

// ===== hdl/dmra_end_ctrl.sv =====
`timescale 1ns / 1ps
// End registers, lock flags and command decision for both ends of the region.
module dmra_end_ctrl #(
  parameter int ADDR_BITS  = 16,
  parameter int LINK_BYTES = 2,
  parameter int MARK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_init,
  input  logic [15:0]       cfg_size,
  input  logic              item_go,
  input  logic [3:0]        opcode,
  input  logic [15:0]       amount,
  input  logic [15:0]       new_pointer,
  output dmra_pkg::result_t result
);
  import dmra_pkg::*;

  localparam int SUM_W = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
  localparam int CNT_W = $clog2(MARK_DEPTH + 1);
  localparam logic [SUM_W-1:0] ADDR_MASK_W = (SUM_W'(1) << ADDR_BITS) - SUM_W'(1);
  localparam logic [SUM_W-1:0] LINK_W      = SUM_W'(LINK_BYTES);
  localparam logic [SUM_W-1:0] TWO_LINK_W  = SUM_W'(2 * LINK_BYTES);
  localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(MARK_DEPTH);

  function automatic logic [ADDR_BITS-1:0] bottom_start(input logic [15:0] size);
    logic [SUM_W-1:0] eff;
    begin
      eff = SUM_W'(size);
      if (eff > ADDR_MASK_W) begin
        eff = ADDR_MASK_W;
      end
      if (eff < TWO_LINK_W) begin
        bottom_start = ADDR_BITS'(LINK_W);
      end else begin
        bottom_start = ADDR_BITS'(eff - LINK_W);
      end
    end
  endfunction

  logic [ADDR_BITS-1:0] top_end, top_end_next;
  logic [ADDR_BITS-1:0] bottom_end, bottom_end_next;
  logic                 top_is_locked, top_is_locked_next;
  logic                 bottom_is_locked, bottom_is_locked_next;

  stack_cmd_t           top_cmd, bot_cmd;
  logic [ADDR_BITS-1:0] top_push_data, bot_push_data;
  logic [CNT_W-1:0]     top_count, bot_count;
  logic [ADDR_BITS-1:0] top_tos, bot_tos;

  logic [SUM_W-1:0] te, be, amt, newp, top_v, bot_v;
  logic [SUM_W-1:0] te_plus_amt, te_plus_link;

  assign te   = SUM_W'(top_end);
  assign be   = SUM_W'(bottom_end);
  assign amt  = SUM_W'(amount);
  assign newp = SUM_W'(new_pointer) & ADDR_MASK_W;
  assign top_v = SUM_W'(top_tos);
  assign bot_v = SUM_W'(bot_tos);
  // both ends test growth as top + size > bottom, which never underflows
  assign te_plus_amt  = te + amt;
  assign te_plus_link = te + LINK_W;

  assign top_push_data = top_end;
  assign bot_push_data = bottom_end;

  always_comb begin
    top_end_next          = top_end;
    bottom_end_next       = bottom_end;
    top_is_locked_next    = top_is_locked;
    bottom_is_locked_next = bottom_is_locked;
    top_cmd               = '0;
    bot_cmd               = '0;
    result.address        = '0;
    result.status         = ST_OK;
    if (cfg_init) begin
      top_end_next          = ADDR_BITS'(LINK_W);
      bottom_end_next       = bottom_start(cfg_size);
      top_is_locked_next    = 1'b0;
      bottom_is_locked_next = 1'b0;
      top_cmd.clear         = 1'b1;
      bot_cmd.clear         = 1'b1;
    end else if (item_go) begin
      case (opcode_t'(opcode))
        OP_INIT: begin
          top_end_next          = ADDR_BITS'(LINK_W);
          bottom_end_next       = bottom_start(cfg_size);
          top_is_locked_next    = 1'b0;
          bottom_is_locked_next = 1'b0;
          top_cmd.clear         = 1'b1;
          bot_cmd.clear         = 1'b1;
        end
        OP_TOP_LOCK: begin
          if (top_is_locked) begin
            result.status = ST_TOP_LOCKED;
          end else begin
            top_is_locked_next = 1'b1;
            result.address     = te[15:0];
          end
        end
        OP_TOP_UNLOCK: begin
          if (!top_is_locked) begin
            result.status = ST_TOP_UNLOCKED;
          end else if (newp > be) begin
            result.status = ST_OOM;
          end else begin
            top_is_locked_next = 1'b0;
            top_end_next       = ADDR_BITS'(newp);
          end
        end
        OP_TOP_MARK: begin
          if (top_is_locked) begin
            result.status = ST_TOP_LOCKED;
          end else if (top_count >= FULL_COUNT) begin
            result.status = ST_MARKS_FULL;
          end else if (te_plus_link > be) begin
            result.status = ST_OOM;
          end else begin
            top_cmd.push = 1'b1;
            top_end_next = ADDR_BITS'(te_plus_link);
          end
        end
        OP_TOP_ALLOC: begin
          if (top_is_locked) begin
            result.status = ST_TOP_LOCKED;
          end else if (te_plus_amt > be) begin
            result.status = ST_OOM;
          end else begin
            result.address = te[15:0];
            top_end_next    = ADDR_BITS'(te_plus_amt);
          end
        end
        OP_TOP_FREE: begin
          if (top_is_locked) begin
            result.status = ST_TOP_LOCKED;
          end else if (top_count == '0) begin
            result.status = ST_NO_MARK;
          end else if (top_v > be) begin
            result.status = ST_OOM;
          end else begin
            top_cmd.pop  = 1'b1;
            top_end_next = top_tos;
          end
        end
        OP_BOT_LOCK: begin
          if (bottom_is_locked) begin
            result.status = ST_BOT_LOCKED;
          end else begin
            bottom_is_locked_next = 1'b1;
            result.address        = be[15:0];
          end
        end
        OP_BOT_UNLOCK: begin
          if (!bottom_is_locked) begin
            result.status = ST_BOT_UNLOCKED;
          end else if (newp < te) begin
            result.status = ST_OOM;
          end else begin
            bottom_is_locked_next = 1'b0;
            bottom_end_next       = ADDR_BITS'(newp);
          end
        end
        OP_BOT_ALLOC: begin
          if (bottom_is_locked) begin
            result.status = ST_BOT_LOCKED;
          end else if (te_plus_amt > be) begin
            result.status = ST_OOM;
          end else begin
            bottom_end_next = ADDR_BITS'(be - amt);
            result.address  = 16'(be - amt);
          end
        end
        OP_BOT_MARK: begin
          if (bottom_is_locked) begin
            result.status = ST_BOT_LOCKED;
          end else if (bot_count >= FULL_COUNT) begin
            result.status = ST_MARKS_FULL;
          end else if (te_plus_link > be) begin
            result.status = ST_OOM;
          end else begin
            bot_cmd.push    = 1'b1;
            bottom_end_next = ADDR_BITS'(be - LINK_W);
          end
        end
        OP_BOT_FREE: begin
          if (bottom_is_locked) begin
            result.status = ST_BOT_LOCKED;
          end else if (bot_count == '0) begin
            result.status = ST_NO_MARK;
          end else if (bot_v < te) begin
            result.status = ST_OOM;
          end else begin
            bot_cmd.pop     = 1'b1;
            bottom_end_next = bot_tos;
          end
        end
        default: begin
          result.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_end          <= ADDR_BITS'(LINK_W);
      bottom_end       <= bottom_start(REGION_SIZE_RESET);
      top_is_locked    <= 1'b0;
      bottom_is_locked <= 1'b0;
    end else begin
      top_end          <= top_end_next;
      bottom_end       <= bottom_end_next;
      top_is_locked    <= top_is_locked_next;
      bottom_is_locked <= bottom_is_locked_next;
    end
  end

  dmra_mark_stack #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MARK_DEPTH)
  ) u_top_marks (
    .clk       (clk),
    .rst       (rst),
    .cmd       (top_cmd),
    .push_data (top_push_data),
    .count     (top_count),
    .tos       (top_tos)
  );

  dmra_mark_stack #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MARK_DEPTH)
  ) u_bot_marks (
    .clk       (clk),
    .rst       (rst),
    .cmd       (bot_cmd),
    .push_data (bot_push_data),
    .count     (bot_count),
    .tos       (bot_tos)
  );

  a_ends_never_cross: assert property (@(posedge clk) disable iff (rst)
    top_end <= bottom_end)
    else $error("top end above bottom end");
  a_failed_cmd_holds_ends: assert property (@(posedge clk) disable iff (rst)
    item_go && !cfg_init && result.status != ST_OK |=>
      $stable(top_end) && $stable(bottom_end))
    else $error("failed command moved an end");

endmodule

// ===== hdl/double_ended_mark_release_allocator.sv =====
`timescale 1ns / 1ps
// Top level: command register, allocator core, result register and APB port.
//
//   channel  signals                              beat carries
//   cmd      cmd_valid / cmd_stall                opcode, amount, new_pointer
//   rsp      rsp_valid / rsp_stall                address, status
//   apb      psel penable pwrite paddr pwdata     region_size at byte 0
//
// One command per cycle while the result side does not stall. An accepted
// beat goes into the command register, then through the end logic into the
// result register. The end registers and mark stacks update as the result
// register loads, so back-to-back commands see each other's effects.
// Synchronous reset sets region_size to 32000 and both ends to their start;
// no clearing pass is needed. A stalled result holds the result register and,
// once the command register is full too, raises cmd_stall.
module double_ended_mark_release_allocator #(
  parameter int ADDR_BITS  = 16,
  parameter int LINK_BYTES = 2,
  parameter int MARK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [3:0]  opcode,
  input  logic [15:0] amount,
  input  logic [15:0] new_pointer,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] address,
  output logic [2:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dmra_pkg::*;

  logic        cmd_held;
  logic [3:0]  held_opcode;
  logic [15:0] held_amount;
  logic [15:0] held_new_pointer;
  logic        rsp_free;
  logic        advance;
  logic        cmd_take;
  logic        cfg_write;
  logic [15:0] region_size;
  logic [15:0] init_size;
  result_t     core_result;

  // APB: always ready, one register at byte 0; writes above it are dropped
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_REGION_SIZE);
  assign prdata    = (paddr[2] == REG_REGION_SIZE) ? {16'd0, region_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= REGION_SIZE_RESET;
    end else if (cfg_write) begin
      region_size <= pwdata[15:0];
    end
  end

  // a register write reinitialises with the new size in the same cycle
  assign init_size = cfg_write ? pwdata[15:0] : region_size;

  // advance the held command when the result register is empty or draining
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign advance   = cmd_held && rsp_free;
  assign cmd_stall = cmd_held && !rsp_free;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held <= 1'b0;
    end else if (cmd_take) begin
      cmd_held <= 1'b1;
    end else if (advance) begin
      cmd_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      held_opcode      <= opcode;
      held_amount      <= amount;
      held_new_pointer <= new_pointer;
    end
  end

  dmra_end_ctrl #(
    .ADDR_BITS  (ADDR_BITS),
    .LINK_BYTES (LINK_BYTES),
    .MARK_DEPTH (MARK_DEPTH)
  ) u_end_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_init    (cfg_write),
    .cfg_size    (init_size),
    .item_go     (advance),
    .opcode      (held_opcode),
    .amount      (held_amount),
    .new_pointer (held_new_pointer),
    .result      (core_result)
  );

  // result register: load on advance, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      address <= core_result.address;
      status  <= core_result.status;
    end
  end

  a_fail_has_zero_address: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> address == 16'd0)
    else $error("failed command returned an address");
  a_held_cmd_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced command produced no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

// ===== tb/sv/double_ended_mark_release_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended mark/release allocator.
module double_ended_mark_release_allocator_test;
  import dmra_pkg::*;

  localparam int ADDR_BITS  = 16;
  localparam int LINK_BYTES = 2;
  localparam int MARK_DEPTH = 16;

  // Opcodes past the last defined command; the block must ignore them.
  localparam logic [3:0] SPARE_OP_LO = 4'(OP_BOT_FREE) + 4'd1;
  localparam logic [3:0] SPARE_OP_HI = 4'hF;

  localparam logic [2:0] REGION_SIZE_ADDR = 3'(4 * REG_REGION_SIZE);

  localparam int REPORT_LIMIT      = 10;
  localparam int LONG_HOLD_CYCLES  = 150;
  localparam int PIPE_DRAIN_CYCLES = 8;
  localparam int MAX_WAIT          = 11;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] amount;
    logic [15:0] new_pointer;
  } command_t;

  // ---------------------------------------------------------------------------
  // Block ports
  // ---------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cmd_valid   = 1'b0;
  logic        cmd_stall;
  logic [3:0]  opcode      = '0;
  logic [15:0] amount      = '0;
  logic [15:0] new_pointer = '0;
  logic        rsp_valid;
  logic        rsp_stall   = 1'b0;
  logic [15:0] address;
  logic [2:0]  status;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  double_ended_mark_release_allocator #(
    .ADDR_BITS (ADDR_BITS),
    .LINK_BYTES(LINK_BYTES),
    .MARK_DEPTH(MARK_DEPTH)
  ) dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator predictor: its own copy of the ends, locks and mark stacks
  // ---------------------------------------------------------------------------
  logic [15:0] region_size;
  logic [15:0] top_end;
  logic [15:0] bottom_end;
  logic        top_lock_flag;
  logic        bottom_lock_flag;
  logic [15:0] top_marks    [MARK_DEPTH];
  logic [15:0] bottom_marks [MARK_DEPTH];
  logic [4:0]  top_mark_count;
  logic [4:0]  bottom_mark_count;

  // Bring both ends back to their start. The region is never wider than the
  // 16-bit address space here, so no clipping of region_size is needed. A region
  // too small for two link words leaves the ends touching.
  function automatic void restart_ends();
    top_end = 16'(LINK_BYTES);
    if (region_size < 2 * LINK_BYTES) begin
      bottom_end = top_end;
    end else begin
      bottom_end = region_size - 16'(LINK_BYTES);
    end
    top_lock_flag     = 1'b0;
    bottom_lock_flag  = 1'b0;
    top_mark_count    = '0;
    bottom_mark_count = '0;
  endfunction

  // Work out the result of one command and advance the predicted state.
  // Lock state is checked first, then the mark stack, then overlap of the ends.
  function automatic result_t allocator_step(command_t c);
    result_t     r;
    logic [15:0] popped;
    r.address = '0;
    r.status  = ST_OK;
    case (c.opcode)
      OP_INIT: restart_ends();
      OP_TOP_LOCK: begin
        if (top_lock_flag) begin
          r.status = ST_TOP_LOCKED;
        end else begin
          top_lock_flag = 1'b1;
          r.address     = top_end;
        end
      end
      OP_TOP_UNLOCK: begin
        if (!top_lock_flag) begin
          r.status = ST_TOP_UNLOCKED;
        end else if (c.new_pointer > bottom_end) begin
          r.status = ST_OOM;
        end else begin
          top_lock_flag = 1'b0;
          top_end       = c.new_pointer;
        end
      end
      OP_TOP_MARK: begin
        if (top_lock_flag) begin
          r.status = ST_TOP_LOCKED;
        end else if (top_mark_count >= MARK_DEPTH) begin
          r.status = ST_MARKS_FULL;
        end else if ({1'b0, top_end} + 17'(LINK_BYTES) > {1'b0, bottom_end}) begin
          r.status = ST_OOM;
        end else begin
          top_marks[top_mark_count] = top_end;
          top_mark_count++;
          top_end = top_end + 16'(LINK_BYTES);
        end
      end
      OP_TOP_ALLOC: begin
        if (top_lock_flag) begin
          r.status = ST_TOP_LOCKED;
        end else if ({1'b0, top_end} + {1'b0, c.amount} > {1'b0, bottom_end}) begin
          r.status = ST_OOM;
        end else begin
          r.address = top_end;
          top_end   = top_end + c.amount;
        end
      end
      OP_TOP_FREE: begin
        if (top_lock_flag) begin
          r.status = ST_TOP_LOCKED;
        end else if (top_mark_count == 0) begin
          r.status = ST_NO_MARK;
        end else begin
          popped = top_marks[top_mark_count - 1];
          if (popped > bottom_end) begin
            r.status = ST_OOM;
          end else begin
            top_mark_count--;
            top_end = popped;
          end
        end
      end
      OP_BOT_LOCK: begin
        if (bottom_lock_flag) begin
          r.status = ST_BOT_LOCKED;
        end else begin
          bottom_lock_flag = 1'b1;
          r.address        = bottom_end;
        end
      end
      OP_BOT_UNLOCK: begin
        if (!bottom_lock_flag) begin
          r.status = ST_BOT_UNLOCKED;
        end else if (c.new_pointer < top_end) begin
          r.status = ST_OOM;
        end else begin
          bottom_lock_flag = 1'b0;
          bottom_end       = c.new_pointer;
        end
      end
      OP_BOT_ALLOC: begin
        if (bottom_lock_flag) begin
          r.status = ST_BOT_LOCKED;
        end else if (c.amount > bottom_end || bottom_end - c.amount < top_end) begin
          r.status = ST_OOM;
        end else begin
          bottom_end = bottom_end - c.amount;
          r.address  = bottom_end;
        end
      end
      OP_BOT_MARK: begin
        if (bottom_lock_flag) begin
          r.status = ST_BOT_LOCKED;
        end else if (bottom_mark_count >= MARK_DEPTH) begin
          r.status = ST_MARKS_FULL;
        end else if (bottom_end < LINK_BYTES ||
                     bottom_end - 16'(LINK_BYTES) < top_end) begin
          r.status = ST_OOM;
        end else begin
          bottom_marks[bottom_mark_count] = bottom_end;
          bottom_mark_count++;
          bottom_end = bottom_end - 16'(LINK_BYTES);
        end
      end
      OP_BOT_FREE: begin
        if (bottom_lock_flag) begin
          r.status = ST_BOT_LOCKED;
        end else if (bottom_mark_count == 0) begin
          r.status = ST_NO_MARK;
        end else begin
          popped = bottom_marks[bottom_mark_count - 1];
          if (popped < top_end) begin
            r.status = ST_OOM;
          end else begin
            bottom_mark_count--;
            bottom_end = popped;
          end
        end
      end
      default: ;  // spare opcodes: no effect, zero result
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  command_t command_backlog[$];
  result_t  expected_results[$];

  int unsigned mismatch_count    = 0;
  int unsigned commands_sent     = 0;
  int unsigned results_seen      = 0;
  int unsigned settings_written  = 0;
  int unsigned input_stall_beats = 0;
  int unsigned status_hits [8]   = '{default: 0};

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: one beat at a time from the backlog, with a random gap
  // before each. Predict at the edge that accepts the beat, so that the
  // expectation order is the block's own order. Assign cmd_valid exactly once
  // per edge so a back-to-back beat never drops valid for a delta.
  // ---------------------------------------------------------------------------
  command_t    cmd_on_wire;
  int unsigned send_wait     = 0;
  bit          sender_steady = 1'b0;

  always @(posedge clk) begin : drive_commands
    logic next_valid;
    next_valid = cmd_valid;
    if (!rst) begin
      if (cmd_valid && cmd_stall) input_stall_beats++;
      if (cmd_valid && !cmd_stall) begin
        expected_results.push_back(allocator_step(cmd_on_wire));
        commands_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (command_backlog.size() != 0) begin
          cmd_on_wire  = command_backlog.pop_front();
          opcode      <= cmd_on_wire.opcode;
          amount      <= cmd_on_wire.amount;
          new_pointer <= cmd_on_wire.new_pointer;
          next_valid   = 1'b1;
          // Switch now and then between back-to-back beats and idle gaps.
          if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
          send_wait = sender_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end
      end
    end
    cmd_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once, well into the run, stall the result side for a long
  // stretch while commands keep coming, so the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  logic        drain_hold = 1'b0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && commands_sent > 300 && command_backlog.size() > 20) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      drain_hold <= (hold_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare every accepted result beat with the oldest
  // expectation, then draw how long to stall before taking the next one.
  // ---------------------------------------------------------------------------
  int unsigned stall_left      = 0;
  bit          receiver_steady = 1'b0;

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, {address, status});
        end else begin
          want = expected_results.pop_front();
          if (address !== want.address) flag_mismatch("address", want.address, address);
          if (status !== want.status) flag_mismatch("status", want.status, status);
          status_hits[want.status]++;
        end
        if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
        stall_left = receiver_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_stall <= drain_hold || (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic [3:0] op, logic [15:0] amt = '0,
                                    logic [15:0] ptr = '0);
    command_t c;
    c.opcode      = op;
    c.amount      = amt;
    c.new_pointer = ptr;
    command_backlog.push_back(c);
  endfunction

  // Mostly small blocks, with zero, the full range and region-sized amounts mixed in.
  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3:       return 16'($urandom_range(0, region_size));
      default: return 16'($urandom_range(1, 48));
    endcase
  endfunction

  // New end pointers: near the end's start mostly, sometimes anywhere.
  function automatic logic [15:0] pick_pointer(bit top);
    int hi;
    int lo;
    hi = region_size;
    lo = (hi > 300) ? hi - 300 : 0;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return top ? 16'($urandom_range(0, 300)) : 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // One well-formed sequence with random content, or a single noise command.
  function automatic void queue_random_sequence();
    bit top;
    int depth;
    top = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0, 1: begin
        // mark, a few allocations, release back to the mark
        queue_cmd(top ? OP_TOP_MARK : OP_BOT_MARK);
        repeat ($urandom_range(1, 4)) queue_cmd(top ? OP_TOP_ALLOC : OP_BOT_ALLOC, pick_amount());
        queue_cmd(top ? OP_TOP_FREE : OP_BOT_FREE);
      end
      2, 3: begin
        // lock, sometimes poke the locked end, then unlock at a new pointer
        queue_cmd(top ? OP_TOP_LOCK : OP_BOT_LOCK);
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       queue_cmd(top ? OP_TOP_LOCK : OP_BOT_LOCK);
            1:       queue_cmd(top ? OP_TOP_ALLOC : OP_BOT_ALLOC, pick_amount());
            2:       queue_cmd(top ? OP_TOP_MARK : OP_BOT_MARK);
            default: queue_cmd(top ? OP_TOP_FREE : OP_BOT_FREE);
          endcase
        end
        queue_cmd(top ? OP_TOP_UNLOCK : OP_BOT_UNLOCK, '0, pick_pointer(top));
      end
      4: begin
        // deep nesting: run the mark stack close to full, at times past it, then unwind
        depth = $urandom_range(MARK_DEPTH - 4, MARK_DEPTH + 2);
        repeat (depth) queue_cmd(top ? OP_TOP_MARK : OP_BOT_MARK);
        repeat (depth + $urandom_range(0, 1)) queue_cmd(top ? OP_TOP_FREE : OP_BOT_FREE);
      end
      5: begin
        // allocations from both ends towards each other
        repeat ($urandom_range(3, 6)) begin
          queue_cmd($urandom_range(0, 1) ? OP_TOP_ALLOC : OP_BOT_ALLOC, pick_amount());
        end
      end
      6: begin
        if ($urandom_range(0, 3) == 0) queue_cmd(OP_INIT);
        queue_cmd(top ? OP_TOP_ALLOC : OP_BOT_ALLOC, pick_amount());
      end
      default: begin
        // noise: any opcode, spare ones included, with raw field values
        queue_cmd(4'($urandom_range(0, SPARE_OP_HI)), 16'($urandom), 16'($urandom));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  // Look at the queues on the falling edge, where every beat of the rising
  // edge has settled, then let the pipeline run dry.
  task automatic wait_idle();
    do @(negedge clk);
    while (command_backlog.size() != 0 || cmd_valid || expected_results.size() != 0);
    repeat (PIPE_DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write region_size over APB (setup then access), mirror it in the
  // predictor, then read it back.
  task automatic write_region_size(input logic [15:0] size);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REGION_SIZE_ADDR;
    pwdata  <= {16'd0, size};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    region_size = size;
    restart_ends();
    settings_written++;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== size) flag_mismatch("region_size read-back", size, prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [15:0] size, input int unsigned count);
    write_region_size(size);
    while (command_backlog.size() < count) queue_random_sequence();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    region_size = REGION_SIZE_RESET;
    restart_ends();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: lock rules, unlock extremes, empty and full amounts, no-mark
    // frees and the spare opcodes, all on the reset region.
    queue_cmd(OP_TOP_ALLOC, 16'd0);
    queue_cmd(OP_TOP_LOCK);
    queue_cmd(OP_TOP_LOCK);
    queue_cmd(OP_TOP_ALLOC, 16'd8);
    queue_cmd(OP_TOP_UNLOCK, '0, 16'hFFFF);
    queue_cmd(OP_TOP_UNLOCK, '0, 16'h0000);
    queue_cmd(OP_TOP_UNLOCK, '0, 16'd4);
    queue_cmd(OP_TOP_FREE);
    queue_cmd(OP_TOP_MARK);
    queue_cmd(OP_TOP_ALLOC, 16'hFFFF);
    queue_cmd(OP_TOP_ALLOC, 16'd100);
    queue_cmd(OP_TOP_FREE);
    queue_cmd(OP_BOT_LOCK);
    queue_cmd(OP_BOT_MARK);
    queue_cmd(OP_BOT_UNLOCK, '0, 16'hFFFF);
    queue_cmd(OP_BOT_ALLOC, 16'hFFFF);
    queue_cmd(OP_INIT);
    queue_cmd(OP_BOT_ALLOC, 16'h8000);
    queue_cmd(OP_BOT_ALLOC, 16'd64);
    queue_cmd(OP_BOT_MARK);
    queue_cmd(OP_BOT_FREE);
    queue_cmd(OP_BOT_FREE);
    queue_cmd(OP_BOT_UNLOCK, '0, 16'd0);
    queue_cmd(SPARE_OP_LO, 16'hFFFF, 16'hFFFF);
    queue_cmd(SPARE_OP_HI, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // Random phases over several region sizes: a small one of 16 bytes, the
    // full address space, a region too small for two link words, and more.
    run_random_phase(16'd16, 170);
    run_random_phase(16'hFFFF, 200);
    run_random_phase(16'd3, 60);
    run_random_phase(16'd1000, 200);
    run_random_phase(16'($urandom_range(16, 65535)), 250);

    // Hold a few more cycles for any stray result beat.
    repeat (PIPE_DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_mismatch("results still outstanding", '0, expected_results.size());
    end

    $display("Summary: %0d commands, %0d result beats, %0d region settings, %0d stalled cycles",
             commands_sent, results_seen, settings_written, input_stall_beats);
    $display("Status mix: ok %0d, oom %0d, tl %0d, tu %0d, bl %0d, bu %0d, nomark %0d, full %0d",
             status_hits[ST_OK], status_hits[ST_OOM], status_hits[ST_TOP_LOCKED],
             status_hits[ST_TOP_UNLOCKED], status_hits[ST_BOT_LOCKED],
             status_hits[ST_BOT_UNLOCKED], status_hits[ST_NO_MARK], status_hits[ST_MARKS_FULL]);
    if (mismatch_count == 0) begin
      $display("double_ended_mark_release_allocator test passed");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("double_ended_mark_release_allocator test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("double_ended_mark_release_allocator test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dmra_pkg.sv
hdl/dmra_mark_stack.sv
hdl/dmra_end_ctrl.sv
hdl/double_ended_mark_release_allocator.sv
tb/sv/double_ended_mark_release_allocator_test.sv
